// ===== rtl/dpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpmc_pkg
// Types, character codes and key-string tables shared by the message
// classifier modules.
// ----------------------------------------------------------------------------
package dpmc_pkg;

    // Longest message accepted before the item is flagged too long
    localparam int unsigned MAX_MESSAGE_BYTES = 65535;
    localparam int unsigned POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);

    // Fixed offsets inside the event header
    localparam int unsigned NAME_START = 11;

    // Result kinds
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_D   = 8'h64;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_H   = 8'h68;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_L   = 8'h6C;
    localparam logic [7:0] CH_LC_M   = 8'h6D;
    localparam logic [7:0] CH_LC_O   = 8'h6F;
    localparam logic [7:0] CH_LC_P   = 8'h70;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               well_formed;
        logic [15:0]        method_offset;
        logic [15:0]        method_length;
        logic [15:0]        payload_offset;
        logic [15:0]        payload_length;
        logic signed [31:0] reply_id;
        logic               success;
        logic               too_long;
    } out_item_t;

    typedef enum logic [10:0] {
        PH_HEAD     = 11'b000_0000_0001,
        PH_EVHEAD   = 11'b000_0000_0010,
        PH_IDHEAD   = 11'b000_0000_0100,
        PH_METHOD   = 11'b000_0000_1000,
        PH_PKEY     = 11'b000_0001_0000,
        PH_EVPAY    = 11'b000_0010_0000,
        PH_ID       = 11'b000_0100_0000,
        PH_RKEY     = 11'b000_1000_0000,
        PH_RKEYREST = 11'b001_0000_0000,
        PH_RESPAY   = 11'b010_0000_0000,
        PH_FAIL     = 11'b100_0000_0000
    } phase_t;

    // {"method":"
    function automatic logic [7:0] ev_head_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CH_LBRACE;
            4'd1:    c = CH_QUOTE;
            4'd2:    c = CH_LC_M;
            4'd3:    c = CH_LC_E;
            4'd4:    c = CH_LC_T;
            4'd5:    c = CH_LC_H;
            4'd6:    c = CH_LC_O;
            4'd7:    c = CH_LC_D;
            4'd8:    c = CH_QUOTE;
            4'd9:    c = CH_COLON;
            4'd10:   c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {"id":
    function automatic logic [7:0] id_head_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CH_LBRACE;
            4'd1:    c = CH_QUOTE;
            4'd2:    c = CH_LC_I;
            4'd3:    c = CH_LC_D;
            4'd4:    c = CH_QUOTE;
            4'd5:    c = CH_COLON;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ,"params":
    function automatic logic [7:0] params_key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CH_COMMA;
            4'd1:    c = CH_QUOTE;
            4'd2:    c = CH_LC_P;
            4'd3:    c = CH_LC_A;
            4'd4:    c = CH_LC_R;
            4'd5:    c = CH_LC_A;
            4'd6:    c = CH_LC_M;
            4'd7:    c = CH_LC_S;
            4'd8:    c = CH_QUOTE;
            4'd9:    c = CH_COLON;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "result":
    function automatic logic [7:0] result_key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CH_QUOTE;
            4'd1:    c = CH_LC_R;
            4'd2:    c = CH_LC_E;
            4'd3:    c = CH_LC_S;
            4'd4:    c = CH_LC_U;
            4'd5:    c = CH_LC_L;
            4'd6:    c = CH_LC_T;
            4'd7:    c = CH_QUOTE;
            4'd8:    c = CH_COLON;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "error":
    function automatic logic [7:0] error_key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CH_QUOTE;
            4'd1:    c = CH_LC_E;
            4'd2:    c = CH_LC_R;
            4'd3:    c = CH_LC_R;
            4'd4:    c = CH_LC_O;
            4'd5:    c = CH_LC_R;
            4'd6:    c = CH_QUOTE;
            4'd7:    c = CH_COLON;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/dpmc_in_stage.sv =====
// ----------------------------------------------------------------------------
// dpmc_in_stage
// Input register: holds one byte item until the parser consumes it.
// ----------------------------------------------------------------------------
module dpmc_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dpmc_pkg::in_item_t s_data,
    input  logic               take,
    output logic               item_valid,
    output dpmc_pkg::in_item_t item
);
    import dpmc_pkg::*;

    logic     valid_reg;
    in_item_t data_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== rtl/dpmc_parse_core.sv =====
// ----------------------------------------------------------------------------
// dpmc_parse_core
// Per-byte parser: phase machine, position and id counters, and the
// combinational classification of the final byte of a message.
// ----------------------------------------------------------------------------
module dpmc_parse_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dpmc_pkg::in_item_t  item,
    output dpmc_pkg::out_item_t result
);
    import dpmc_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_MSTRT = POS_W'(NAME_START);
    localparam logic [35:0]      LIM_POS   = 36'h0_7FFF_FFFF;
    localparam logic [35:0]      LIM_NEG   = 36'h0_8000_0000;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] mend_reg, mend_next;
    logic [POS_W-1:0] ps_reg, ps_next;
    logic [31:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             digit_reg, digit_next;
    logic             len_ovf_reg, len_ovf_next;
    logic             first_open_reg, first_open_next;
    logic [7:0]       prev_reg;
    logic [7:0]       pfb_reg, pfb_next;
    logic             succ_reg, succ_next;
    logic [3:0]       koff_reg, koff_next;

    logic [7:0]       b;
    logic             last;
    logic             no_params;
    logic             is_digit;
    logic [3:0]       dval;
    logic [35:0]      acc_x10;
    logic [35:0]      id_lim;
    logic [7:0]       rkey_char;
    logic [3:0]       rkey_last;
    logic [POS_W-1:0] span;
    logic             payload_ok;

    assign b        = item.data_byte;
    assign last     = item.end_of_message;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign dval     = 4'(b - CH_ZERO);
    assign acc_x10  = (36'(acc_reg) << 3) + (36'(acc_reg) << 1) + 36'(dval);
    assign id_lim   = neg_reg ? LIM_NEG : LIM_POS;
    assign rkey_char = succ_reg ? result_key_char(koff_reg) : error_key_char(koff_reg);
    assign rkey_last = succ_reg ? 4'd8 : 4'd7;

    always_comb begin
        phase_next      = phase_reg;
        mend_next       = mend_reg;
        ps_next         = ps_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        digit_next      = digit_reg;
        len_ovf_next    = len_ovf_reg;
        first_open_next = first_open_reg;
        pfb_next        = pfb_reg;
        succ_next       = succ_reg;
        koff_next       = koff_reg;
        no_params       = 1'b0;

        if (pos_reg >= POS_MAX) begin
            len_ovf_next = 1'b1;
            phase_next   = PH_FAIL;
        end else begin
            if (pos_reg == '0) begin
                first_open_next = (b == CH_LBRACE);
            end
            no_params = last && (phase_reg == PH_PKEY) && (koff_reg == 4'd0);

            unique case (phase_reg)
                PH_HEAD: begin
                    if (pos_reg < POS_W'(2)) begin
                        if (b != ev_head_char(pos_reg[3:0])) phase_next = PH_FAIL;
                    end else if (b == CH_LC_M) begin
                        phase_next = PH_EVHEAD;
                    end else if (b == CH_LC_I) begin
                        phase_next = PH_IDHEAD;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_EVHEAD: begin
                    if (pos_reg >= POS_W'(11) || b != ev_head_char(pos_reg[3:0])) begin
                        phase_next = PH_FAIL;
                    end else if (pos_reg == POS_W'(10)) begin
                        phase_next = PH_METHOD;
                    end
                end
                PH_IDHEAD: begin
                    if (pos_reg >= POS_W'(6) || b != id_head_char(pos_reg[3:0])) begin
                        phase_next = PH_FAIL;
                    end else if (pos_reg == POS_W'(5)) begin
                        phase_next = PH_ID;
                    end
                end
                PH_METHOD: begin
                    if (b == CH_QUOTE) begin
                        if (pos_reg == POS_MSTRT) begin
                            phase_next = PH_FAIL;
                        end else begin
                            mend_next  = pos_reg;
                            koff_next  = 4'd0;
                            phase_next = PH_PKEY;
                        end
                    end
                end
                PH_PKEY: begin
                    koff_next = koff_reg + 4'd1;
                    if (koff_reg >= 4'd10 || b != params_key_char(koff_reg)) begin
                        phase_next = PH_FAIL;
                    end else if (koff_reg == 4'd9) begin
                        ps_next    = pos_reg + POS_W'(1);
                        phase_next = PH_EVPAY;
                    end
                end
                PH_ID: begin
                    if (pos_reg == POS_W'(6) && (b == CH_MINUS || b == CH_PLUS)) begin
                        if (b == CH_MINUS) neg_next = 1'b1;
                    end else if (is_digit) begin
                        digit_next = 1'b1;
                        if (acc_x10 > id_lim) begin
                            phase_next = PH_FAIL;
                        end else begin
                            acc_next = acc_x10[31:0];
                        end
                    end else if (b == CH_COMMA && digit_reg) begin
                        mend_next  = pos_reg;
                        koff_next  = 4'd0;
                        phase_next = PH_RKEY;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_RKEY: begin
                    koff_next = koff_reg + 4'd1;
                    if (koff_reg == 4'd0) begin
                        if (b != CH_QUOTE) phase_next = PH_FAIL;
                    end else if (b == CH_LC_R) begin
                        succ_next  = 1'b1;
                        phase_next = PH_RKEYREST;
                    end else if (b == CH_LC_E) begin
                        succ_next  = 1'b0;
                        phase_next = PH_RKEYREST;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_RKEYREST: begin
                    koff_next = koff_reg + 4'd1;
                    if (koff_reg > rkey_last || b != rkey_char) begin
                        phase_next = PH_FAIL;
                    end else if (koff_reg == rkey_last) begin
                        ps_next    = pos_reg + POS_W'(1);
                        phase_next = PH_RESPAY;
                    end
                end
                PH_EVPAY, PH_RESPAY: begin
                    if (pos_reg == ps_reg) pfb_next = b;
                end
                default: begin
                end
            endcase
        end

        pos_next = len_ovf_next ? pos_reg : pos_reg + POS_W'(1);
    end

    // Classify on the final byte, using the post-update state
    assign span       = pos_reg - ps_next;
    assign payload_ok = (pos_reg >= ps_next) && (span >= POS_W'(2))
                        && (pfb_next == CH_LBRACE) && (prev_reg == CH_RBRACE);

    always_comb begin
        result      = '0;
        result.kind = KIND_FAIL;
        result.too_long = len_ovf_next;
        if (!len_ovf_next) begin
            result.well_formed = (pos_reg >= POS_W'(2)) && first_open_next
                                 && (b == CH_RBRACE);
            if (no_params) begin
                result.kind          = KIND_EVENT;
                result.method_offset = 16'(NAME_START);
                result.method_length = 16'(mend_reg - POS_MSTRT);
            end else if ((phase_next == PH_EVPAY || phase_next == PH_RESPAY) && payload_ok) begin
                result.payload_offset = 16'(ps_next);
                result.payload_length = 16'(span);
                if (phase_next == PH_EVPAY) begin
                    result.kind          = KIND_EVENT;
                    result.method_offset = 16'(NAME_START);
                    result.method_length = 16'(mend_reg - POS_MSTRT);
                end else begin
                    result.kind     = KIND_REPLY;
                    result.success  = succ_reg;
                    result.reply_id = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
                end
            end
        end
    end

    // Clear everything at the end of each message
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            phase_reg      <= PH_HEAD;
            pos_reg        <= '0;
            mend_reg       <= '0;
            ps_reg         <= '0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            digit_reg      <= 1'b0;
            len_ovf_reg    <= 1'b0;
            first_open_reg <= 1'b0;
            prev_reg       <= '0;
            pfb_reg        <= '0;
            succ_reg       <= 1'b0;
            koff_reg       <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            mend_reg       <= mend_next;
            ps_reg         <= ps_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            digit_reg      <= digit_next;
            len_ovf_reg    <= len_ovf_next;
            first_open_reg <= first_open_next;
            prev_reg       <= b;
            pfb_reg        <= pfb_next;
            succ_reg       <= succ_next;
            koff_reg       <= koff_next;
        end
    end

endmodule

// ===== rtl/dpmc_out_stage.sv =====
// ----------------------------------------------------------------------------
// dpmc_out_stage
// Result register: holds one classification item until the sink takes it.
// ----------------------------------------------------------------------------
module dpmc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  dpmc_pkg::out_item_t result,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output dpmc_pkg::out_item_t m_data
);
    import dpmc_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// ===== rtl/debug_protocol_message_classifier_top.sv =====
// ----------------------------------------------------------------------------
// debug_protocol_message_classifier_top
// Classifies a byte-streamed debug-protocol message as event, reply or failure.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle while no final byte is stalled (see Stalls).
// Result path: the final byte passes the input register, then the result register,
//   which presents the result item as soon as it has loaded it.
// Stalls: a final byte waits only while the result register holds an unread item.
// Reset: synchronous, active low; clears the parser state and both stages.
//   No clearing pass; a byte may be accepted as soon as reset is released.
module debug_protocol_message_classifier_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dpmc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dpmc_pkg::out_item_t m_data
);
    import dpmc_pkg::*;

    in_item_t  item;
    out_item_t result;
    logic      item_valid;
    logic      out_free;
    logic      take;
    logic      load;

    // A final byte waits for room in the result register; others go at once
    assign take = item_valid && (!item.end_of_message || out_free);
    assign load = take && item.end_of_message;

    dpmc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dpmc_parse_core u_parse_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .item    (item),
        .result  (result)
    );

    dpmc_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sim/debug_protocol_message_classifier_top_tb.sv =====
// ----------------------------------------------------------------------------
// debug_protocol_message_classifier_top_tb
// Streams debug-protocol messages into the classifier one byte item at a time:
// a directed set of events, replies, id limits and malformed messages, then
// random well-formed, corrupted and noise messages. A scoreboard predicts the
// result item of each message and checks the block's output field by field,
// with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module debug_protocol_message_classifier_top_tb;

    import dpmc_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_BYTES  = 840;

    class classifier_scoreboard;
        out_item_t   expected_q[$];
        int          errors;

        string       ev_prefix  = "{\"method\":\"";
        string       id_prefix  = "{\"id\":";
        string       params_key = ",\"params\":";
        string       result_key = "\"result\":";
        string       error_key  = "\"error\":";

        int unsigned cur_pos;
        phase_t      phase;
        int unsigned name_end;
        int unsigned pay_start;
        int unsigned id_mag;
        bit          id_neg;
        bit          id_digit;
        logic [7:0]  last_byte;
        logic [7:0]  pay_first;
        bit          reply_ok;
        bit          over_len;
        bit          opened;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            cur_pos    = 0;
            phase      = PH_HEAD;
            name_end   = 0;
            pay_start  = 0;
            id_mag     = 0;
            id_neg     = 0;
            id_digit   = 0;
            last_byte  = 8'h00;
            pay_first  = 8'h00;
            reply_ok   = 0;
            over_len   = 0;
            opened     = 0;
        endfunction

        function void parse_byte(logic [7:0] b, int unsigned p);
            int unsigned off;
            int unsigned lim;
            int unsigned d;
            string       key;
            off = p - (name_end + 1);
            case (phase)
                PH_HEAD: begin
                    if (p < 2) begin
                        if (b != ev_prefix[p]) phase = PH_FAIL;
                    end else if (b == CH_LC_M) begin
                        phase = PH_EVHEAD;
                    end else if (b == CH_LC_I) begin
                        phase = PH_IDHEAD;
                    end else begin
                        phase = PH_FAIL;
                    end
                end
                PH_EVHEAD: begin
                    if (p >= ev_prefix.len() || b != ev_prefix[p]) phase = PH_FAIL;
                    else if (p == ev_prefix.len() - 1) phase = PH_METHOD;
                end
                PH_IDHEAD: begin
                    if (p >= id_prefix.len() || b != id_prefix[p]) phase = PH_FAIL;
                    else if (p == id_prefix.len() - 1) phase = PH_ID;
                end
                PH_METHOD: begin
                    if (b == CH_QUOTE) begin
                        if (p == NAME_START) begin
                            phase = PH_FAIL;
                        end else begin
                            name_end = p;
                            phase    = PH_PKEY;
                        end
                    end
                end
                PH_PKEY: begin
                    if (off >= params_key.len() || b != params_key[off]) begin
                        phase = PH_FAIL;
                    end else if (off == params_key.len() - 1) begin
                        pay_start = p + 1;
                        phase     = PH_EVPAY;
                    end
                end
                PH_ID: begin
                    if (p == id_prefix.len() && (b == CH_MINUS || b == CH_PLUS)) begin
                        if (b == CH_MINUS) id_neg = 1;
                    end else if (b >= CH_ZERO && b <= CH_NINE) begin
                        d        = b - CH_ZERO;
                        lim      = id_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        id_digit = 1;
                        // refuse the digit once the magnitude would leave int32
                        if (id_mag > (lim - d) / 10) phase = PH_FAIL;
                        else id_mag = id_mag * 10 + d;
                    end else if (b == CH_COMMA && id_digit) begin
                        name_end = p;
                        phase    = PH_RKEY;
                    end else begin
                        phase = PH_FAIL;
                    end
                end
                PH_RKEY: begin
                    if (off == 0) begin
                        if (b != CH_QUOTE) phase = PH_FAIL;
                    end else if (b == CH_LC_R) begin
                        reply_ok = 1;
                        phase    = PH_RKEYREST;
                    end else if (b == CH_LC_E) begin
                        reply_ok = 0;
                        phase    = PH_RKEYREST;
                    end else begin
                        phase = PH_FAIL;
                    end
                end
                PH_RKEYREST: begin
                    key = reply_ok ? result_key : error_key;
                    if (off >= key.len() || b != key[off]) begin
                        phase = PH_FAIL;
                    end else if (off == key.len() - 1) begin
                        pay_start = p + 1;
                        phase     = PH_RESPAY;
                    end
                end
                PH_EVPAY, PH_RESPAY: begin
                    if (p == pay_start) pay_first = b;
                end
                default: ;
            endcase
        endfunction

        // Predict one accepted byte; the final byte of a message queues a result.
        function void note_byte(logic [7:0] b, logic is_last);
            int unsigned p;
            logic [7:0]  prev;
            bit          no_params;
            out_item_t   r;
            p         = cur_pos;
            prev      = last_byte;
            no_params = 0;
            if (p >= MAX_MESSAGE_BYTES) begin
                over_len = 1;
                phase    = PH_FAIL;
            end else begin
                if (p == 0) opened = (b == CH_LBRACE);
                no_params = is_last && phase == PH_PKEY && p == name_end + 1;
                parse_byte(b, p);
            end
            if (!is_last) begin
                if (!over_len) cur_pos = p + 1;
                last_byte = b;
                return;
            end
            r      = '0;
            r.kind = KIND_FAIL;
            if (!over_len) begin
                r.well_formed = (p >= 2 && opened && b == CH_RBRACE);
                if (no_params) begin
                    r.kind          = KIND_EVENT;
                    r.method_offset = 16'(NAME_START);
                    r.method_length = 16'(name_end - NAME_START);
                end else if (phase == PH_EVPAY || phase == PH_RESPAY) begin
                    if (p >= pay_start + 2 && pay_first == CH_LBRACE && prev == CH_RBRACE) begin
                        r.payload_offset = 16'(pay_start);
                        r.payload_length = 16'(p - pay_start);
                        if (phase == PH_EVPAY) begin
                            r.kind          = KIND_EVENT;
                            r.method_offset = 16'(NAME_START);
                            r.method_length = 16'(name_end - NAME_START);
                        end else begin
                            r.kind     = KIND_REPLY;
                            r.success  = reply_ok;
                            r.reply_id = 32'(id_neg ? 0 - id_mag : id_mag);
                        end
                    end
                end
            end
            r.too_long = over_len;
            expected_q.push_back(r);
            clear_state();
        endfunction

        function void compare_field(string name, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $error("result item with no expectation pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("well_formed", want.well_formed, got.well_formed);
            compare_field("method_offset", want.method_offset, got.method_offset);
            compare_field("method_length", want.method_length, got.method_length);
            compare_field("payload_offset", want.payload_offset, got.payload_offset);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("reply_id", $signed(want.reply_id), $signed(got.reply_id));
            compare_field("success", want.success, got.success);
            compare_field("too_long", want.too_long, got.too_long);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;

    classifier_scoreboard sb = new();

    int          src_idle;
    int          dst_idle;
    int          random_bytes;
    logic [7:0]  msg_q[$];

    debug_protocol_message_classifier_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: check every accepted item, stall at random.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= ($urandom_range(99) >= dst_idle);
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("debug_protocol_message_classifier_top_tb NOT OK");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, end_of_message: is_last};
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_byte(b, is_last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], i == msg_q.size() - 1);
        random_bytes += msg_q.size();
        msg_q.delete();
    endtask

    // Hold the input side until every queued result has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endtask

    task automatic add_random(input int n);
        repeat (n) msg_q.push_back(rand_byte());
    endtask

    task automatic add_name(input int n);
        logic [7:0] c;
        repeat (n) begin
            do c = rand_byte(); while (c == CH_QUOTE);
            msg_q.push_back(c);
        end
    endtask

    // Braced object, now and then defective or missing.
    task automatic add_payload();
        int t;
        t = $urandom_range(99);
        if (t < 3) return;
        msg_q.push_back(t < 10 ? rand_byte() : CH_LBRACE);
        add_random($urandom_range(0, 12));
        msg_q.push_back((t >= 10 && t < 17) ? rand_byte() : CH_RBRACE);
    endtask

    task automatic add_final();
        msg_q.push_back($urandom_range(9) == 0 ? rand_byte() : CH_RBRACE);
    endtask

    task automatic add_id();
        longint unsigned mag;
        int              sel;
        int              sgn;
        sel = $urandom_range(9);
        case (sel)
            4:       mag = $urandom;
            5:       mag = 64'd2147483647;
            6:       mag = 64'd2147483648;
            7:       mag = 64'd2147483649;
            8:       mag = 64'd4294967295;
            9:       mag = 64'd98765432109;
            default: mag = $urandom_range(0, 999);
        endcase
        sgn = $urandom_range(3);
        if (sgn == 0) msg_q.push_back(CH_MINUS);
        else if (sgn == 1) msg_q.push_back(CH_PLUS);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) msg_q.push_back(CH_ZERO);
        if ($urandom_range(19) != 0) add_str($sformatf("%0d", mag));
    endtask

    task automatic build_event(input bit with_params);
        add_str("{\"method\":\"");
        add_name($urandom_range(19) == 0 ? 0 : $urandom_range(1, 10));
        msg_q.push_back(CH_QUOTE);
        if (with_params) begin
            add_str(",\"params\":");
            add_payload();
        end
        add_final();
    endtask

    task automatic build_reply();
        add_str("{\"id\":");
        add_id();
        add_str($urandom_range(1) ? ",\"result\":" : ",\"error\":");
        add_payload();
        add_final();
    endtask

    task automatic run_directed();
        add_str("{\"method\":\"Page.loadEventFired\"}");                 send_message();
        add_str("{\"method\":\"A\",\"params\":{}}");                      send_message();
        add_str("{\"method\":\"X\""); msg_q.push_back(8'h00);              send_message();
        add_str("{\"method\":\"\"}");                                    send_message();
        add_str("{\"id\":0,\"result\":{}}");                              send_message();
        add_str("{\"id\":2147483647,\"result\":{\"a\":1}}");              send_message();
        add_str("{\"id\":-2147483648,\"error\":{\"code\":-1}}");          send_message();
        add_str("{\"id\":2147483648,\"result\":{}}");                     send_message();
        add_str("{\"id\":-2147483649,\"result\":{}}");                    send_message();
        add_str("{\"id\":+17,\"error\":{}}");                             send_message();
        add_str("{\"id\":-,\"result\":{}}");                              send_message();
        add_str("{\"id\":5,\"result\":{}");                               send_message();
        add_str("{\"id\":007,\"result\":{}}");                            send_message();
        add_str("{\"method\":\"m\",\"params\":[1]}");                     send_message();
        add_str("{\"method\":\"m\",\"params\":{1]}");                     send_message();
        add_str("{\"method\":\"n\",\"extra\":{}}");                       send_message();
        add_str("{");                                                    send_message();
        add_str("{}");                                                   send_message();
        add_str("{x}");                                                  send_message();
        repeat (4) msg_q.push_back(8'hFF);                               send_message();
        add_str("{\"method\":\"");
        msg_q.push_back(8'h80); msg_q.push_back(8'hFF); msg_q.push_back(8'h7F);
        add_str("\"}");                                                  send_message();
    endtask

    task automatic run_random();
        int sel;
        int keep;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            case (random_bytes * 3 / RANDOM_BYTES)
                0:       begin src_idle = 18; dst_idle = 52; end
                1:       begin src_idle = 52; dst_idle = 18; end
                default: begin src_idle = 0;  dst_idle = 0;  end
            endcase
            sel = $urandom_range(99);
            if (sel < 15) begin
                build_event(1'b0);
            end else if (sel < 40) begin
                build_event(1'b1);
            end else if (sel < 75) begin
                build_reply();
            end else if (sel < 90) begin
                // corrupt a well-formed message: overwrite one byte or cut it short
                if ($urandom_range(1)) build_reply();
                else build_event(1'($urandom_range(1)));
                if ($urandom_range(1)) begin
                    msg_q[$urandom_range(msg_q.size() - 1)] = rand_byte();
                end else begin
                    keep = $urandom_range(1, msg_q.size());
                    while (msg_q.size() > keep) void'(msg_q.pop_back());
                end
            end else begin
                if ($urandom_range(1)) msg_q.push_back(CH_LBRACE);
                add_random($urandom_range(1, 30));
            end
            send_message();
            if ($urandom_range(19) == 0) wait_drained();
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_data   <= '0;
        src_idle  = 18;
        dst_idle  = 52;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_drained();
        run_random();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("debug_protocol_message_classifier_top_tb OK");
        else
            $display("debug_protocol_message_classifier_top_tb NOT OK");
        $finish;
    end

endmodule
